// ===== rtl/core/segment_index_box_parser_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SEGMENT_INDEX_BOX_PARSER_ASSERT_SVH
`define SEGMENT_INDEX_BOX_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIDX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SIDX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/sidx_pkg.sv =====
// ----------------------------------------------------------------------------
// sidx_pkg
// Types and constants shared by the segment index box parser.
// ----------------------------------------------------------------------------
package sidx_pkg;

  localparam int PhaseW = 6;

  localparam logic [PhaseW-1:0] PH_VERSION = 6'd0;
  localparam logic [PhaseW-1:0] PH_REF_ID  = 6'd7;
  localparam logic [PhaseW-1:0] PH_SCALE   = 6'd11;
  localparam logic [PhaseW-1:0] PH_TIME_N  = 6'd15;
  localparam logic [PhaseW-1:0] PH_TIME_W  = 6'd19;
  localparam logic [PhaseW-1:0] PH_FO_N    = 6'd19;
  localparam logic [PhaseW-1:0] PH_FO_W    = 6'd27;
  localparam logic [PhaseW-1:0] PH_COUNT_N = 6'd23;
  localparam logic [PhaseW-1:0] PH_COUNT_W = 6'd31;
  localparam logic [PhaseW-1:0] PH_ENTRY   = 6'd32;
  localparam logic [PhaseW-1:0] PH_LAST    = 6'd43;
  localparam logic [PhaseW-1:0] PH_DONE    = 6'd63;

  localparam logic [2:0]  SAP_TYPE_MASK  = 3'h7;
  localparam logic [27:0] SAP_DELTA_MASK = 28'h0fffffff;

  localparam int OutDataW = 288;

  typedef enum logic [1:0] {
    ST_ENTRY     = 2'd0,
    ST_ENTRY_END = 2'd1,
    ST_END       = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_box;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] reference_id_out;
    logic [31:0] timescale_out;
    logic [63:0] byte_location;
    logic [63:0] seg_time;
    logic [27:0] sap_delta;
    logic [2:0]  sap_code;
    logic        sap_start;
    logic [31:0] seg_duration;
    logic [30:0] ref_size;
    logic        ref_kind;
  } result_t;

endpackage

// ===== rtl/core/segment_index_box_parser.sv =====
// Path: a byte passes the input register, then the result register to m_tdata.
// Throughput: one payload byte per cycle while the result buffer has space,
// held by the 64-bit accumulator adds in the parser core; a byte causes at
// most one result.
// Reset: synchronous rst clears the parser state, the anchor offset and both
// beat buffers; the parser then waits for the version byte of a new box.
// ----------------------------------------------------------------------------
// segment_index_box_parser
// Byte-serial segment index box parser with registered input and output.
// ----------------------------------------------------------------------------
module segment_index_box_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // end_of_box
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] ref_kind, [31:1] ref_size, [63:32] seg_duration,
  // [64] sap_start, [67:65] sap_code, [95:68] sap_delta,
  // [159:96] seg_time, [223:160] byte_location, [255:224] timescale_out,
  // [287:256] reference_id_out
  output logic [287:0] m_tdata,
  output logic [1:0]   m_tuser    // [1:0] status
);
  import sidx_pkg::*;

  in_beat_t beat;
  logic     take;
  logic     space;
  logic     res_valid;
  result_t  res;
  result_t  head;

  sidx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .beat     (beat)
  );

  sidx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .beat      (beat),
    .space     (space),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  sidx_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .head      (head)
  );

  assign m_tuser = head.status;
  assign m_tdata = {head.reference_id_out, head.timescale_out, head.byte_location,
                    head.seg_time, head.sap_delta, head.sap_code,
                    head.sap_start, head.seg_duration,
                    head.ref_size, head.ref_kind};

endmodule

// ===== rtl/core/sidx_in_stage.sv =====
// ----------------------------------------------------------------------------
// sidx_in_stage
// Input register: captures one payload beat for the parser core.
// ----------------------------------------------------------------------------
module sidx_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic              take,
  output sidx_pkg::in_beat_t beat
);
  import sidx_pkg::*;

  logic       valid;
  logic [7:0] data_byte;
  logic       end_of_box;

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte  <= s_tdata;
      end_of_box <= s_tlast;
    end
  end

  always_comb begin
    beat.valid      = valid;
    beat.data_byte  = data_byte;
    beat.end_of_box = end_of_box;
  end

endmodule

// ===== rtl/core/sidx_core.sv =====
// ----------------------------------------------------------------------------
// sidx_core
// Header capture, reference decode and time/location accumulators.
// ----------------------------------------------------------------------------
module sidx_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  sidx_pkg::in_beat_t beat,
  input  logic               space,
  output logic               take,
  output logic               res_valid,
  output sidx_pkg::result_t  res
);
  import sidx_pkg::*;

  logic [63:0]       anchor_offset;
  logic [PhaseW-1:0] phase, phase_next;
  logic [7:0]        box_version, box_version_next;
  logic [63:0]       header_shift, header_shift_next;
  logic [31:0]       stream_id, stream_id_next;
  logic [31:0]       scale, scale_next;
  logic [63:0]       time_acc, time_acc_next;
  logic [63:0]       loc_acc, loc_acc_next;
  logic [15:0]       entries_left, entries_left_next;
  logic [31:0]       entry_words [3];
  logic [31:0]       entry_words_next [3];

  logic [63:0] shift_step;
  logic [63:0] hdr_value;
  logic [31:0] w2_step;
  logic [7:0]  ver_step;
  logic        wide;
  logic        in_header;
  logic        in_entry;
  logic        ent;
  logic        complete;

  assign take = beat.valid && space;

  always_comb begin
    phase_next        = phase;
    box_version_next  = box_version;
    header_shift_next = header_shift;
    stream_id_next    = stream_id;
    scale_next        = scale;
    time_acc_next     = time_acc;
    loc_acc_next      = loc_acc;
    entries_left_next = entries_left;
    for (int i = 0; i < 3; i++) begin
      entry_words_next[i] = entry_words[i];
    end
    ent      = 1'b0;
    complete = 1'b0;

    shift_step = {header_shift[55:0], beat.data_byte};
    ver_step   = (phase == PH_VERSION) ? beat.data_byte : box_version;
    wide       = (ver_step != 8'd0);
    hdr_value  = wide ? shift_step : {32'd0, shift_step[31:0]};
    w2_step    = {entry_words[2][23:0], beat.data_byte};
    in_header  = (phase < PH_ENTRY);
    in_entry   = (phase >= PH_ENTRY) && (phase <= PH_LAST);

    res                     = '0;
    res.status              = ST_ENTRY;

    if (in_header) begin
      header_shift_next = shift_step;
      box_version_next  = ver_step;
      phase_next        = phase + 6'd1;
      priority if (phase == PH_REF_ID) begin
        stream_id_next = shift_step[31:0];
      end else if (phase == PH_SCALE) begin
        scale_next = shift_step[31:0];
      end else if (phase == (wide ? PH_TIME_W : PH_TIME_N)) begin
        time_acc_next = hdr_value;
      end else if (phase == (wide ? PH_FO_W : PH_FO_N)) begin
        loc_acc_next = anchor_offset + hdr_value;
      end else if (phase == (wide ? PH_COUNT_W : PH_COUNT_N)) begin
        entries_left_next = shift_step[15:0];
        phase_next        = (shift_step[15:0] != 16'd0) ? PH_ENTRY : PH_DONE;
      end else begin
        // hold
      end
    end else if (in_entry) begin
      unique case (phase[3:2])
        2'd0:    entry_words_next[0] = {entry_words[0][23:0], beat.data_byte};
        2'd1:    entry_words_next[1] = {entry_words[1][23:0], beat.data_byte};
        default: entry_words_next[2] = w2_step;
      endcase
      phase_next = phase + 6'd1;
      if (phase == PH_LAST) begin
        ent                = 1'b1;
        res.ref_kind       = entry_words[0][31];
        res.ref_size       = entry_words[0][30:0];
        res.seg_duration   = entry_words[1];
        res.sap_start      = w2_step[31];
        res.sap_code       = w2_step[30:28] & SAP_TYPE_MASK;
        res.sap_delta      = w2_step[27:0] & SAP_DELTA_MASK;
        res.seg_time       = time_acc;
        res.byte_location  = loc_acc;
        time_acc_next      = time_acc + {32'd0, entry_words[1]};
        loc_acc_next       = loc_acc + {33'd0, entry_words[0][30:0]};
        entries_left_next  = entries_left - 16'd1;
        phase_next = (entries_left_next != 16'd0) ? PH_ENTRY : PH_DONE;
      end
    end

    if (beat.end_of_box) begin
      complete = (phase_next == PH_DONE);
      if (ent) begin
        res.status = complete ? ST_ENTRY_END : ST_TRUNC;
      end else begin
        res.status = complete ? ST_END : ST_TRUNC;
      end
      phase_next        = PH_VERSION;
      header_shift_next = '0;
      entries_left_next = '0;
      for (int i = 0; i < 3; i++) begin
        entry_words_next[i] = '0;
      end
    end

    res.timescale_out    = scale_next;
    res.reference_id_out = stream_id_next;
    res_valid            = take && (ent || beat.end_of_box);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_offset <= '0;
    end else if (cfg_we) begin
      anchor_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_VERSION;
      box_version  <= '0;
      header_shift <= '0;
      stream_id    <= '0;
      scale        <= '0;
      time_acc     <= '0;
      loc_acc      <= '0;
      entries_left <= '0;
      for (int i = 0; i < 3; i++) begin
        entry_words[i] <= '0;
      end
    end else if (take) begin
      phase        <= phase_next;
      box_version  <= box_version_next;
      header_shift <= header_shift_next;
      stream_id    <= stream_id_next;
      scale        <= scale_next;
      time_acc     <= time_acc_next;
      loc_acc      <= loc_acc_next;
      entries_left <= entries_left_next;
      for (int i = 0; i < 3; i++) begin
        entry_words[i] <= entry_words_next[i];
      end
    end
  end

endmodule

// ===== rtl/core/sidx_out_buf.sv =====
// ----------------------------------------------------------------------------
// sidx_out_buf
// Two-entry result buffer: head register drives the output, spare holds
// a beat while the sink stalls.
// ----------------------------------------------------------------------------
module sidx_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sidx_pkg::result_t push_data,
  output logic              space,
  output logic              m_tvalid,
  input  logic              m_tready,
  output sidx_pkg::result_t head
);
  import sidx_pkg::*;

  logic    head_valid;
  logic    spare_valid;
  result_t spare;
  logic    pop;

  assign space    = !spare_valid;
  assign m_tvalid = head_valid;
  assign pop      = head_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      priority if (pop && spare_valid) begin
        spare_valid <= push;
      end else if (pop) begin
        head_valid <= push;
      end else if (push && head_valid) begin
        spare_valid <= 1'b1;
      end else if (push) begin
        head_valid <= 1'b1;
      end else begin
        // hold
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (pop && spare_valid) begin
      head <= spare;
      if (push) begin
        spare <= push_data;
      end
    end else if (pop) begin
      if (push) begin
        head <= push_data;
      end
    end else if (push && head_valid) begin
      spare <= push_data;
    end else if (push) begin
      head <= push_data;
    end else begin
      // hold
    end
  end

endmodule

// ===== rtl/core/sidx_checker.sv =====
// ----------------------------------------------------------------------------
// sidx_checker
// Port-level checks on the segment index box parser.
// ----------------------------------------------------------------------------
`include "segment_index_box_parser_assert.svh"

module sidx_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [287:0] m_tdata,
  input logic [1:0]   m_tuser
);
  import sidx_pkg::*;

  `SIDX_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  `SIDX_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  `SIDX_ASSERT_NOW(a_end_fields_zero, clk, rst, m_tvalid && (m_tuser == ST_END), m_tdata[223:0] == 224'd0)

endmodule

bind segment_index_box_parser sidx_checker u_sidx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
